FILE: hw/rtl/ztsd_pkg.sv
package ztsd_pkg;

	localparam logic [1:0] OP_RESET   = 2'd0;
	localparam logic [1:0] OP_PASS    = 2'd1;
	localparam logic [1:0] OP_DECRYPT = 2'd2;

	localparam logic [31:0] KEY_ZERO_INIT = 32'h1234_5678;
	localparam logic [31:0] KEY_ONE_INIT  = 32'h2345_6789;
	localparam logic [31:0] KEY_TWO_INIT  = 32'h3456_7890;
	localparam logic [31:0] LCG_MULT      = 32'd134775813;
	localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;

	typedef struct packed {
		logic load_in;
		logic init_keys;
		logic ks_en;
		logic ks_xor;
		logic out_load;
		logic k0_en;
		logic k1_en;
		logic k2_en;
	} dp_cmd_t;

	// reflected CRC-32 byte step, no inversion
	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] x;
		x = {24'd0, c[7:0] ^ b};
		for (int i = 0; i < 8; i++) begin
			if (x[0]) begin
				x = (x >> 1) ^ CRC_POLY;
			end else begin
				x = x >> 1;
			end
		end
		return x ^ (c >> 8);
	endfunction

endpackage

FILE: hw/rtl/ztsd_ctrl.sv
module ztsd_ctrl
	import ztsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] op,
	output logic       in_stall,
	input  logic       out_stall,
	output logic       out_valid,
	output dp_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_KS   = 3'd1;
	localparam logic [2:0] ST_K0   = 3'd2;
	localparam logic [2:0] ST_K1   = 3'd3;
	localparam logic [2:0] ST_K2   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       dec_q;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load_in   = 1'b1;
					cmd.init_keys = (op == OP_RESET);
					if (op == OP_PASS || op == OP_DECRYPT) begin
						state_d = ST_KS;
					end
				end
			end
			ST_KS: begin
				if (!dec_q || out_free) begin
					cmd.ks_en    = 1'b1;
					cmd.ks_xor   = dec_q;
					cmd.out_load = dec_q;
					state_d      = ST_K0;
				end
			end
			ST_K0: begin
				cmd.k0_en = 1'b1;
				state_d   = ST_K1;
			end
			ST_K1: begin
				cmd.k1_en = 1'b1;
				state_d   = ST_K2;
			end
			ST_K2: begin
				cmd.k2_en = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dec_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				dec_q <= (op == OP_DECRYPT);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/ztsd_dp.sv
module ztsd_dp
	import ztsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	input  logic [7:0] data_byte,
	output logic [7:0] plain_byte
);

	logic [31:0] key_zero_q;
	logic [31:0] key_one_q;
	logic [31:0] key_two_q;
	logic [7:0]  data_q;
	logic [7:0]  byte_q;
	logic [31:0] sum_q;
	logic [7:0]  plain_q;
	logic [15:0] t;
	logic [15:0] prod;
	logic [7:0]  ks;
	logic [7:0]  stir_byte;
	logic [31:0] k0_next;
	logic [31:0] lcg;

	assign t         = key_two_q[15:0] | 16'd2;
	assign prod      = t * (t ^ 16'd1);
	assign ks        = prod[15:8];
	assign stir_byte = cmd.ks_xor ? (data_q ^ ks) : data_q;
	assign k0_next   = crc_step(key_zero_q, byte_q);
	assign lcg       = sum_q * LCG_MULT + 32'd1;
	assign plain_byte = plain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_zero_q <= KEY_ZERO_INIT;
			key_one_q  <= KEY_ONE_INIT;
			key_two_q  <= KEY_TWO_INIT;
		end else if (cmd.init_keys) begin
			key_zero_q <= KEY_ZERO_INIT;
			key_one_q  <= KEY_ONE_INIT;
			key_two_q  <= KEY_TWO_INIT;
		end else begin
			if (cmd.k0_en) begin
				key_zero_q <= k0_next;
			end
			if (cmd.k1_en) begin
				key_one_q <= lcg;
			end
			if (cmd.k2_en) begin
				key_two_q <= crc_step(key_two_q, key_one_q[31:24]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			data_q <= data_byte;
		end
		if (cmd.ks_en) begin
			byte_q <= stir_byte;
		end
		if (cmd.out_load) begin
			plain_q <= stir_byte;
		end
		if (cmd.k0_en) begin
			sum_q <= key_one_q + {24'd0, k0_next[7:0]};
		end
	end

endmodule

FILE: hw/rtl/zip_traditional_stream_decrypt_unit.sv
// channel  | handshake            | payload
// request  | in_valid / in_stall  | op[1:0], data_byte[7:0]
// result   | out_valid / out_stall| plain_byte[7:0]
//
// Password and decrypt requests keep in_stall high after accept while the block steps through
// keystream, then key_zero CRC, key_one multiply, key_two CRC, and returns to idle.
// Reset-keys and unused requests keep the block idle. A decrypt's keystream step sets out_valid.
// arst_n loads the initial key constants and empties the output register.
// A decrypt request waits in the keystream cycle while an earlier result is still stalled.
module zip_traditional_stream_decrypt_unit
	import ztsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] plain_byte
);

	dp_cmd_t cmd;

	ztsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	ztsd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.data_byte  (data_byte),
		.plain_byte (plain_byte)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && out_stall))
		else $error("result overwritten while stalled");

	a_key_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.k0_en |=> cmd.k1_en ##1 cmd.k2_en)
		else $error("key update sequence broken");

	a_reset_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && op == OP_RESET) |=> !in_stall)
		else $error("reset-keys request left block busy");

endmodule
